// ===== sv/ddw_pkg.sv =====
// ----------------------------------------------------------------------------
// Date difference and weekday package
// Shared widths, request and response types, controller interface and the
// calendar helper functions.
// ----------------------------------------------------------------------------
package ddw_pkg;

   localparam int DAY_W       = 5;
   localparam int MON_W       = 4;
   localparam int YEAR_W      = 14;
   localparam int DAYS_W      = 22;
   localparam int WD_W        = 3;
   localparam int MAX_YEAR    = 9999;
   localparam int MONTHS      = 12;
   localparam int RECIP100    = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 13;
   localparam int Q_W         = 8;

   typedef struct packed {
      logic [DAY_W-1:0]  day_a;
      logic [MON_W-1:0]  month_a;
      logic [YEAR_W-1:0] year_a;
      logic [DAY_W-1:0]  day_b;
      logic [MON_W-1:0]  month_b;
      logic [YEAR_W-1:0] year_b;
   } req_type;

   typedef struct packed {
      logic [DAYS_W-1:0] days_between;
      logic [WD_W-1:0]   weekday_a;
      logic              bad_date;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YEAR1,
      ST_YEAR2,
      ST_MONTH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic year1;
      logic year2;
      logic month_step;
      logic store_a;
      logic finish;
      logic sel_b;
   } cmd_type;

   typedef struct packed {
      logic month_more;
      logic out_free;
   } stat_type;

   function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MON_W-1:0] m);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // 8 is 1 mod 7: fold octal digits, then correct once
   function automatic logic [WD_W-1:0] mod7(input logic [DAYS_W:0] x);
      logic [23:0] xe;
      logic [5:0]  s1;
      logic [3:0]  s2;
      logic [3:0]  s3;
      xe = 24'(x);
      s1 = '0;
      for (int i = 0; i < 8; i++) begin
         s1 = s1 + 6'(xe[3*i +: 3]);
      end
      s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
      s3 = 4'(s2[2:0]) + 4'(s2[3]);
      return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
   endfunction

endpackage

// ===== sv/ddw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Date difference controller
// Sequences the year and month steps for date A, then date B, then the
// final difference and weekday.
// ----------------------------------------------------------------------------
module ddw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ddw_pkg::stat_type stat,
   output ddw_pkg::cmd_type  cmd
);
   import ddw_pkg::*;

   state_type state_ff, state_in;
   logic      sel_b_ff, sel_b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_b_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_b_ff <= sel_b_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_b_in = sel_b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_YEAR1;
               sel_b_in = 1'b0;
            end
         end
         ST_YEAR1: state_in = ST_YEAR2;
         ST_YEAR2: state_in = ST_MONTH;
         ST_MONTH: begin
            if (!stat.month_more) begin
               if (!sel_b_ff) begin
                  state_in = ST_YEAR1;
                  sel_b_in = 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd            = '0;
      cmd.sel_b      = sel_b_ff;
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      cmd.year1      = (state_ff == ST_YEAR1);
      cmd.year2      = (state_ff == ST_YEAR2);
      cmd.month_step = (state_ff == ST_MONTH) && stat.month_more;
      cmd.store_a    = (state_ff == ST_MONTH) && !stat.month_more && !sel_b_ff;
      cmd.finish     = (state_ff == ST_FINISH) && stat.out_free;
   end

   a_load_starts_year: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_YEAR1 && !sel_b_ff)
      else $error("request did not start the year step for date A");

   a_month_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MONTH && !stat.month_more |=> state_ff == ST_YEAR1 || state_ff == ST_FINISH)
      else $error("month loop exit went to an unexpected state");

   a_store_then_b: assert property (@(posedge clock) disable iff (reset)
      cmd.store_a |=> sel_b_ff)
      else $error("date B not selected after date A stored");

endmodule

// ===== sv/ddw_datapath.sv =====
// ----------------------------------------------------------------------------
// Date difference datapath
// Request register, shared day-number unit, month accumulator and the
// response register.
// ----------------------------------------------------------------------------
module ddw_datapath (
   input  logic              clock,
   input  logic              reset,
   input  ddw_pkg::req_type  req,
   input  ddw_pkg::cmd_type  cmd,
   output ddw_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ddw_pkg::rsp_type  rsp
);
   import ddw_pkg::*;

   req_type              req_ff;
   logic [YEAR_W-1:0]    p_ff, p_in;
   logic [DAYS_W-1:0]    p365_ff, p365_in;
   logic [Q_W-1:0]       pq_ff, pq_in;
   logic [Q_W-1:0]       yq_ff, yq_in;
   logic [DAYS_W-1:0]    acc_ff, acc_in;
   logic [DAYS_W-1:0]    na_ff;
   logic                 leap_ff, leap_in;
   logic [MON_W-1:0]     mon_ff, mon_in;
   logic                 bad_ff, bad_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [DAY_W-1:0]     d_sel;
   logic [MON_W-1:0]     m_sel;
   logic [YEAR_W-1:0]    y_sel;
   logic [YEAR_W+RECIP_W-1:0] p_prod, y_prod;
   logic [YEAR_W-1:0]    yq100;
   logic                 y_div100;
   logic [DAYS_W-1:0]    year_part;
   logic                 date_bad;
   logic [DAYS_W-1:0]    diff;

   assign d_sel = cmd.sel_b ? req_ff.day_b   : req_ff.day_a;
   assign m_sel = cmd.sel_b ? req_ff.month_b : req_ff.month_a;
   assign y_sel = cmd.sel_b ? req_ff.year_b  : req_ff.year_a;

   // year step 1: p = y - 1, 365p, p/100 and y/100 by reciprocal
   always_comb begin
      p_in    = y_sel - YEAR_W'(1);
      p365_in = DAYS_W'(DAYS_W'(p_in) * DAYS_W'(365));
      p_prod  = (YEAR_W+RECIP_W)'(p_in) * (YEAR_W+RECIP_W)'(RECIP100);
      y_prod  = (YEAR_W+RECIP_W)'(y_sel) * (YEAR_W+RECIP_W)'(RECIP100);
      pq_in   = p_prod[RECIP_SHIFT +: Q_W];
      yq_in   = y_prod[RECIP_SHIFT +: Q_W];
   end

   // year step 2: leap rule, days before the year, validity
   always_comb begin
      yq100     = YEAR_W'(YEAR_W'(yq_ff) * YEAR_W'(100));
      y_div100  = (y_sel == yq100);
      leap_in   = (y_sel[1:0] == 2'b00 && !y_div100) || (y_div100 && yq_ff[1:0] == 2'b00);
      year_part = p365_ff + DAYS_W'(p_ff[YEAR_W-1:2]) - DAYS_W'(pq_ff)
                + DAYS_W'(pq_ff[Q_W-1:2]);
      date_bad  = (y_sel == '0) || (y_sel > YEAR_W'(MAX_YEAR))
               || (m_sel == '0) || (m_sel > MON_W'(MONTHS))
               || (d_sel == '0) || (d_sel > month_len(leap_in, m_sel));
   end

   always_comb begin
      acc_in = acc_ff;
      mon_in = mon_ff;
      bad_in = bad_ff;
      if (cmd.load) begin
         bad_in = 1'b0;
      end
      if (cmd.year2) begin
         acc_in = year_part + DAYS_W'(d_sel) - DAYS_W'(1);
         mon_in = MON_W'(1);
         bad_in = bad_ff | date_bad;
      end
      if (cmd.month_step) begin
         acc_in = acc_ff + DAYS_W'(month_len(leap_ff, mon_ff));
         mon_in = mon_ff + MON_W'(1);
      end
   end

   assign stat.month_more = (mon_ff < m_sel);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // finish: |A - B| and weekday, 1 Jan 1800 being a Wednesday
   always_comb begin
      diff         = (na_ff >= acc_ff) ? (na_ff - acc_ff) : (acc_ff - na_ff);
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_in.bad_date = bad_ff;
         if (bad_ff) begin
            rsp_in.days_between = '0;
            rsp_in.weekday_a    = '0;
         end else begin
            rsp_in.days_between = diff;
            rsp_in.weekday_a    = mod7((DAYS_W+1)'(na_ff) + (DAYS_W+1)'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
      if (cmd.year1) begin
         p_ff    <= p_in;
         p365_ff <= p365_in;
         pq_ff   <= pq_in;
         yq_ff   <= yq_in;
      end
      if (cmd.year2) begin
         leap_ff <= leap_in;
      end
      if (cmd.store_a) begin
         na_ff <= acc_ff;
      end
      acc_ff <= acc_in;
      mon_ff <= mon_in;
      bad_ff <= bad_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.bad_date |-> rsp.days_between == '0 && rsp.weekday_a == '0)
      else $error("bad date response carries nonzero results");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.weekday_a != 3'd7)
      else $error("weekday out of range");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finish did not load the response register");

endmodule

// ===== sv/date_difference_and_weekday_unit.sv =====
// ----------------------------------------------------------------------------
// Date difference and weekday unit
// Absolute day count between two Gregorian dates and the weekday of date A.
// ----------------------------------------------------------------------------
// One request at a time: req_ready is high only while idle, so a new request
// waits until the year and month steps of the shared day-number unit for
// both dates and the finish step are done; finish waits for out_free.
// A new request is taken while the previous response waits in its register.
// Reset clears the controller and the response valid; no memory to clear.
module date_difference_and_weekday_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ddw_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ddw_pkg::rsp_type rsp
);
   import ddw_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ddw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ddw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

// ===== tb/date_difference_and_weekday_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Date difference and weekday unit testbench
// Drives pairs of Gregorian dates through the valid/ready request channel and
// predicts, for each accepted request, the absolute day count between the two
// dates, the weekday of date A and the bad-date flag. Responses are checked in
// order against the predicted queue. A directed set of calendar corner cases
// is followed by random requests under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module date_difference_and_weekday_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ddw_pkg::*;

   localparam int REF_YEAR    = 1800;
   localparam int REF_WEEKDAY = 3;
   localparam int QUIET_LIMIT = 4000;
   localparam int PRINT_CAP   = 40;
   localparam int REQ_W       = $bits(req_type);

   class date_span_board;
      rsp_type owed[$];
      int      errors;

      function bit leap_year(int y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function int month_days(int y, int m);
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      function bit date_valid(int d, int m, int y);
         if (y < 1 || y > MAX_YEAR) return 0;
         if (m < 1 || m > MONTHS) return 0;
         return (d >= 1) && (d <= month_days(y, m));
      endfunction

      function longint serial_day(int d, int m, int y);
         longint p;
         longint n;
         p = y - 1;
         n = 365 * p + p / 4 - p / 100 + p / 400;
         for (int i = 1; i < m; i++) begin
            n += month_days(y, i);
         end
         return n + d - 1;
      endfunction

      function rsp_type span_of(req_type r);
         rsp_type e;
         longint  na;
         longint  nb;
         longint  nref;
         int      wd;
         e = '0;
         if (!date_valid(int'(r.day_a), int'(r.month_a), int'(r.year_a)) ||
             !date_valid(int'(r.day_b), int'(r.month_b), int'(r.year_b))) begin
            e.bad_date = 1'b1;
            return e;
         end
         na = serial_day(int'(r.day_a), int'(r.month_a), int'(r.year_a));
         nb = serial_day(int'(r.day_b), int'(r.month_b), int'(r.year_b));
         e.days_between = DAYS_W'((na >= nb) ? (na - nb) : (nb - na));
         nref = serial_day(1, 1, REF_YEAR);
         if (na >= nref) begin
            wd = (REF_WEEKDAY + int'((na - nref) % 7)) % 7;
         end else begin
            wd = (REF_WEEKDAY + 6 * int'((nref - na) % 7)) % 7;
         end
         e.weekday_a = WD_W'(wd);
         return e;
      endfunction

      function void note_request(req_type r);
         owed.push_back(span_of(r));
      endfunction

      function int pending();
         return owed.size();
      endfunction

      task report(string what);
         errors++;
         if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report($sformatf("response %p with nothing owed", got));
         end else begin
            want = owed.pop_front();
            if (got.days_between !== want.days_between)
               report($sformatf("days_between got %0d want %0d",
                                got.days_between, want.days_between));
            if (got.weekday_a !== want.weekday_a)
               report($sformatf("weekday_a got %0d want %0d",
                                got.weekday_a, want.weekday_a));
            if (got.bad_date !== want.bad_date)
               report($sformatf("bad_date got %0b want %0b", got.bad_date, want.bad_date));
         end
      endtask

      task flag_leftover();
         if (owed.size() != 0) report($sformatf("%0d responses never arrived", owed.size()));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp;

   date_span_board board = new();
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;

   date_difference_and_weekday_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready = reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_response(rsp);
         if (req_valid && req_ready) board.note_request(req);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else if (req_valid || board.pending() != 0) begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("date_difference_and_weekday_unit_tb: errors");
            $finish;
         end
      end
   end

   function automatic int pick_year();
      int specials[15] = '{1, 4, 100, 399, 400, 1600, 1700, 1799, 1800, 1801,
                           1900, 2000, 2100, 9996, 9999};
      if ($urandom_range(4) == 0) return specials[$urandom_range(14)];
      return $urandom_range(MAX_YEAR, 1);
   endfunction

   function automatic int pick_day(int y, int m);
      int len;
      len = board.month_days(y, m);
      return ($urandom_range(6) == 0) ? len : $urandom_range(len, 1);
   endfunction

   function automatic int bad_day(int y, int m);
      int len;
      len = board.month_days(y, m);
      if (len == 31 || $urandom_range(2) == 0) return 0;
      return $urandom_range(31, len + 1);
   endfunction

   function automatic int bad_month();
      return ($urandom_range(2) == 0) ? 0 : $urandom_range(15, MONTHS + 1);
   endfunction

   function automatic int bad_year();
      return ($urandom_range(2) == 0) ? 0 : $urandom_range(16383, MAX_YEAR + 1);
   endfunction

   function automatic req_type pick_req();
      req_type r;
      int      kind;
      int      ya;
      int      ma;
      int      yb;
      int      mb;
      kind = $urandom_range(99);
      ya = pick_year();
      ma = $urandom_range(MONTHS, 1);
      yb = pick_year();
      mb = $urandom_range(MONTHS, 1);
      if (kind < 15) begin
         yb = ya + $urandom_range(2) - 1;
         if (yb < 1) yb = 1;
         if (yb > MAX_YEAR) yb = MAX_YEAR;
      end
      r.year_a  = YEAR_W'(ya);
      r.month_a = MON_W'(ma);
      r.day_a   = DAY_W'(pick_day(ya, ma));
      r.year_b  = YEAR_W'(yb);
      r.month_b = MON_W'(mb);
      r.day_b   = DAY_W'(pick_day(yb, mb));
      if (kind >= 15 && kind < 20) begin
         r.year_b  = r.year_a;
         r.month_b = r.month_a;
         r.day_b   = r.day_a;
      end else if (kind >= 20 && kind < 32) begin
         case ($urandom_range(5))
            0: r.day_a   = DAY_W'(bad_day(ya, ma));
            1: r.month_a = MON_W'(bad_month());
            2: r.year_a  = YEAR_W'(bad_year());
            3: r.day_b   = DAY_W'(bad_day(yb, mb));
            4: r.month_b = MON_W'(bad_month());
            default: r.year_b = YEAR_W'(bad_year());
         endcase
      end else if (kind >= 32 && kind < 40) begin
         r = req_type'(REQ_W'({$urandom, $urandom}));
      end
      return r;
   endfunction

   task automatic send_req(req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req = r;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic send_dates(int da, int ma, int ya, int db, int mb, int yb);
      req_type r;
      r.day_a   = DAY_W'(da);
      r.month_a = MON_W'(ma);
      r.year_a  = YEAR_W'(ya);
      r.day_b   = DAY_W'(db);
      r.month_b = MON_W'(mb);
      r.year_b  = YEAR_W'(yb);
      send_req(r);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int idle_mix[4]  = '{0, 85, 0, 33};
      int stall_mix[4] = '{0, 0, 85, 33};
      int count_mix[4] = '{450, 400, 400, 450};
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      rsp_ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_dates(1, 1, 1, 31, 12, MAX_YEAR);
      send_dates(31, 12, MAX_YEAR, 1, 1, 1);
      send_dates(1, 1, REF_YEAR, 1, 1, REF_YEAR);
      send_dates(31, 12, 1799, 1, 1, REF_YEAR);
      send_dates(1, 1, 1, 1, 1, 1);
      send_dates(29, 2, 2000, 1, 3, 2000);
      send_dates(29, 2, 1900, 1, 3, 1900);
      send_dates(29, 2, 2004, 28, 2, 2004);
      send_dates(29, 2, 2001, 1, 1, 2001);
      send_dates(29, 2, 1600, 31, 12, 1599);
      send_dates(30, 2, 2000, 1, 1, 2000);
      send_dates(15, 0, 2020, 1, 1, 2020);
      send_dates(15, 13, 2020, 1, 1, 2020);
      send_dates(15, 15, 2020, 1, 1, 2020);
      send_dates(0, 5, 2020, 1, 1, 2020);
      send_dates(31, 4, 2020, 1, 1, 2020);
      send_dates(31, 1, 2020, 31, 1, 2021);
      send_dates(1, 1, 0, 1, 1, 2020);
      send_dates(1, 1, MAX_YEAR + 1, 1, 1, 2020);
      send_dates(1, 1, 16383, 1, 1, 2020);
      send_dates(4, 7, 1776, 31, 6, 1776);
      send_dates(12, 6, 2345, 1, 15, 2345);
      drain();

      for (int p = 0; p < 4; p++) begin
         req_idle_pct  = idle_mix[p];
         rsp_stall_pct = stall_mix[p];
         for (int n = 0; n < count_mix[p]; n++) begin
            send_req(pick_req());
         end
         drain();
      end

      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      repeat (60) @(posedge clock);
      board.flag_leftover();
      if (board.errors == 0) begin
         $display("date_difference_and_weekday_unit_tb: clean");
      end else begin
         $display("date_difference_and_weekday_unit_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ddw_pkg.sv
sv/ddw_ctrl.sv
sv/ddw_datapath.sv
sv/date_difference_and_weekday_unit.sv
tb/date_difference_and_weekday_unit_tb.sv
